/* hw/rtl/cmpc_pkg.sv */
// Shared types and constants for the color model pixel classifier with centroid.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package cmpc_pkg;

	localparam int CHAN_W      = 8;
	localparam int COORD_W     = 10;
	localparam int MEAN_W      = 24;
	localparam int COV_W       = 54;
	localparam int COEF_W      = 18;
	localparam int THR_W       = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 54;
	localparam int DIFF_W      = 9;
	localparam int SQ_W        = 18;
	localparam int PROD_W      = 36;
	localparam int PSUM_W      = 38;
	localparam int QW          = 40;
	localparam int SUM_W       = 30;
	localparam int HITS_W      = 21;
	localparam int DIV_CNT_W   = $clog2(SUM_W);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int MAX_WIDTH   = 1024;
	localparam int MAX_HEIGHT  = 1024;
	localparam int POS_CMP_W   = 13;

	localparam logic [MEAN_W-1:0]  MEAN_RESET = 24'h808080;
	localparam logic [SUM_W-1:0]   SUM_MAX    = {SUM_W{1'b1}};
	localparam logic [HITS_W-1:0]  HITS_MAX   = {HITS_W{1'b1}};
	localparam logic [COORD_W-1:0] COORD_MAX  = {COORD_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_MEAN_LAB  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_DIAG  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_CROSS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               fend;
	} pix_meta_t;

	typedef struct packed {
		logic      hit;
		pix_meta_t meta;
	} cls_item_t;

endpackage

`default_nettype wire

/* hw/rtl/cmpc_front.sv */
// Front end: configuration registers and the pipelined Mahalanobis classifier.
// Depends on cmpc_pkg; feeds classified pixels into cmpc_queue.
`default_nettype none

module cmpc_front (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	input  wire  [cmpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [cmpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                 push,
	output logic                                full,
	input  wire  [cmpc_pkg::CHAN_W-1:0]         lightness,
	input  wire  [cmpc_pkg::CHAN_W-1:0]         chroma_a,
	input  wire  [cmpc_pkg::CHAN_W-1:0]         chroma_b,
	input  wire  [cmpc_pkg::COORD_W-1:0]        pixel_x,
	input  wire  [cmpc_pkg::COORD_W-1:0]        pixel_y,
	input  wire                                 frame_end,
	input  wire                                 q_full,
	output logic                                q_push,
	output cmpc_pkg::cls_item_t                 q_item
);

	logic [cmpc_pkg::MEAN_W-1:0] mean_q;
	logic [cmpc_pkg::COV_W-1:0]  diag_q;
	logic [cmpc_pkg::COV_W-1:0]  cross_q;
	logic [cmpc_pkg::THR_W-1:0]  thr_q;

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	cmpc_pkg::pix_meta_t meta_s1, meta_s2, meta_s3, meta_s4, meta_s5;
	logic signed [cmpc_pkg::DIFF_W-1:0] dl_s1, da_s1, db_s1;
	logic signed [cmpc_pkg::SQ_W-1:0]   ll_s2, aa_s2, bb_s2, la_s2, lb_s2, ab_s2;
	logic signed [cmpc_pkg::PROD_W-1:0] pll_s3, paa_s3, pbb_s3, pla_s3, plb_s3, pab_s3;
	logic signed [cmpc_pkg::PSUM_W-1:0] diag_s4, cross_s4;
	logic hit_s5;

	logic signed [cmpc_pkg::COEF_W-1:0] s_ll, s_aa, s_bb, s_la, s_lb, s_ab;
	logic signed [cmpc_pkg::QW-1:0]     q_form;
	logic                               hit_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mean_q  <= cmpc_pkg::MEAN_RESET;
			diag_q  <= '0;
			cross_q <= '0;
			thr_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cmpc_pkg::REG_MEAN_LAB:  mean_q  <= cfg_data[cmpc_pkg::MEAN_W-1:0];
				cmpc_pkg::REG_INV_DIAG:  diag_q  <= cfg_data[cmpc_pkg::COV_W-1:0];
				cmpc_pkg::REG_INV_CROSS: cross_q <= cfg_data[cmpc_pkg::COV_W-1:0];
				cmpc_pkg::REG_THRESHOLD: thr_q   <= cfg_data[cmpc_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	assign adv  = !v_s5 || !q_full;
	assign full = !adv;

	assign s_ll = $signed(diag_q[53:36]);
	assign s_aa = $signed(diag_q[35:18]);
	assign s_bb = $signed(diag_q[17:0]);
	assign s_la = $signed(cross_q[53:36]);
	assign s_lb = $signed(cross_q[35:18]);
	assign s_ab = $signed(cross_q[17:0]);

	assign q_form   = cmpc_pkg::QW'(diag_s4) + (cmpc_pkg::QW'(cross_s4) <<< 1);
	assign hit_next = !q_form[cmpc_pkg::QW-1]
		&& (q_form[cmpc_pkg::QW-2:0] < (cmpc_pkg::QW-1)'(thr_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dl_s1   <= cmpc_pkg::DIFF_W'(lightness) - cmpc_pkg::DIFF_W'(mean_q[23:16]);
			da_s1   <= cmpc_pkg::DIFF_W'(chroma_a) - cmpc_pkg::DIFF_W'(mean_q[15:8]);
			db_s1   <= cmpc_pkg::DIFF_W'(chroma_b) - cmpc_pkg::DIFF_W'(mean_q[7:0]);
			meta_s1 <= '{x: pixel_x, y: pixel_y, fend: frame_end};

			ll_s2   <= dl_s1 * dl_s1;
			aa_s2   <= da_s1 * da_s1;
			bb_s2   <= db_s1 * db_s1;
			la_s2   <= dl_s1 * da_s1;
			lb_s2   <= dl_s1 * db_s1;
			ab_s2   <= da_s1 * db_s1;
			meta_s2 <= meta_s1;

			pll_s3  <= s_ll * ll_s2;
			paa_s3  <= s_aa * aa_s2;
			pbb_s3  <= s_bb * bb_s2;
			pla_s3  <= s_la * la_s2;
			plb_s3  <= s_lb * lb_s2;
			pab_s3  <= s_ab * ab_s2;
			meta_s3 <= meta_s2;

			diag_s4  <= cmpc_pkg::PSUM_W'(pll_s3) + cmpc_pkg::PSUM_W'(paa_s3)
				+ cmpc_pkg::PSUM_W'(pbb_s3);
			cross_s4 <= cmpc_pkg::PSUM_W'(pla_s3) + cmpc_pkg::PSUM_W'(plb_s3)
				+ cmpc_pkg::PSUM_W'(pab_s3);
			meta_s4  <= meta_s3;

			hit_s5  <= hit_next;
			meta_s5 <= meta_s4;
		end
	end

	assign q_push = v_s5 && !q_full;
	assign q_item = '{hit: hit_s5, meta: meta_s5};

endmodule

`default_nettype wire

/* hw/rtl/cmpc_queue.sv */
// Short queue of classified pixels between the front end and the back end.
// Depends on cmpc_pkg for the item type and depth.
`default_nettype none

module cmpc_queue (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  cmpc_pkg::cls_item_t  wr_item,
	output logic                 full,
	input  wire                  pop,
	output cmpc_pkg::cls_item_t  rd_item,
	output logic                 empty
);

	cmpc_pkg::cls_item_t slot_q [cmpc_pkg::QUEUE_DEPTH];
	logic [cmpc_pkg::QPTR_W-1:0] wptr_q, rptr_q;
	logic [cmpc_pkg::QCNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == cmpc_pkg::QCNT_W'(cmpc_pkg::QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cmpc_pkg::QCNT_W'(cmpc_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || full) |-> (wptr_q == rptr_q))
		else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

/* hw/rtl/cmpc_div.sv */
// Restoring divider, one quotient bit per cycle, for the centroid coordinates.
// Depends on cmpc_pkg for operand widths.
`default_nettype none

module cmpc_div (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           start,
	input  wire  [cmpc_pkg::SUM_W-1:0]    num,
	input  wire  [cmpc_pkg::HITS_W-1:0]   den,
	output logic                          busy,
	output logic [cmpc_pkg::SUM_W-1:0]    quo
);

	logic                            busy_q;
	logic [cmpc_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [cmpc_pkg::HITS_W-1:0]     den_q;
	logic [cmpc_pkg::HITS_W-1:0]     rem_q;
	logic [cmpc_pkg::SUM_W-1:0]      quo_q;
	logic [cmpc_pkg::HITS_W:0]       shifted;
	logic                            ge;

	assign shifted = {rem_q, quo_q[cmpc_pkg::SUM_W-1]};
	assign ge      = (shifted >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == cmpc_pkg::DIV_CNT_W'(cmpc_pkg::SUM_W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= ge ? cmpc_pkg::HITS_W'(shifted - {1'b0, den_q})
				: shifted[cmpc_pkg::HITS_W-1:0];
			quo_q <= {quo_q[cmpc_pkg::SUM_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q < cmpc_pkg::DIV_CNT_W'(cmpc_pkg::SUM_W)))
		else $error("divider step count out of range");

endmodule

`default_nettype wire

/* hw/rtl/cmpc_back.sv */
// Back end: accumulates hit positions, divides at a frame end with hits, holds the result.
// Depends on cmpc_pkg and two cmpc_div instances.
`default_nettype none

module cmpc_back (
	input  wire                                clk,
	input  wire                                arst_n,
	input  cmpc_pkg::cls_item_t                q_item,
	input  wire                                q_empty,
	output logic                               q_pop,
	output logic                               empty,
	input  wire                                pop,
	output logic                               in_model,
	output logic                               frame_done,
	output logic [cmpc_pkg::COORD_W-1:0]       centroid_x,
	output logic [cmpc_pkg::COORD_W-1:0]       centroid_y,
	output logic                               centroid_updated,
	output logic [cmpc_pkg::HITS_W-1:0]        hit_count
);

	localparam logic ST_RUN = 1'b0;
	localparam logic ST_DIV = 1'b1;

	logic state_q;
	logic [cmpc_pkg::SUM_W-1:0]   sx_q, sy_q;
	logic [cmpc_pkg::HITS_W-1:0]  hits_q;
	logic [cmpc_pkg::COORD_W-1:0] last_cx_q, last_cy_q;
	logic                         pend_hit_q;
	logic [cmpc_pkg::HITS_W-1:0]  pend_hits_q;

	logic out_valid_q;
	logic out_hit_q, out_fend_q, out_upd_q;
	logic [cmpc_pkg::COORD_W-1:0] out_cx_q, out_cy_q;
	logic [cmpc_pkg::HITS_W-1:0]  out_hits_q;

	logic out_free, take, acc, div_start, finish;
	logic [cmpc_pkg::SUM_W:0]     sx_sum, sy_sum;
	logic [cmpc_pkg::HITS_W:0]    h_sum;
	logic [cmpc_pkg::SUM_W-1:0]   new_sx, new_sy;
	logic [cmpc_pkg::HITS_W-1:0]  new_h;
	logic                         busy_x, busy_y;
	logic [cmpc_pkg::SUM_W-1:0]   quo_x, quo_y;
	logic [cmpc_pkg::COORD_W-1:0] cx, cy;

	assign out_free = !out_valid_q || pop;
	assign take     = (state_q == ST_RUN) && !q_empty && out_free;
	assign q_pop    = take;

	assign acc = q_item.hit
		&& (cmpc_pkg::POS_CMP_W'(q_item.meta.x) < cmpc_pkg::POS_CMP_W'(cmpc_pkg::MAX_WIDTH))
		&& (cmpc_pkg::POS_CMP_W'(q_item.meta.y) < cmpc_pkg::POS_CMP_W'(cmpc_pkg::MAX_HEIGHT));

	assign sx_sum = {1'b0, sx_q} + (cmpc_pkg::SUM_W + 1)'(q_item.meta.x);
	assign sy_sum = {1'b0, sy_q} + (cmpc_pkg::SUM_W + 1)'(q_item.meta.y);
	assign h_sum  = {1'b0, hits_q} + 1'b1;

	assign new_sx = !acc ? sx_q : (sx_sum[cmpc_pkg::SUM_W] ? cmpc_pkg::SUM_MAX
		: sx_sum[cmpc_pkg::SUM_W-1:0]);
	assign new_sy = !acc ? sy_q : (sy_sum[cmpc_pkg::SUM_W] ? cmpc_pkg::SUM_MAX
		: sy_sum[cmpc_pkg::SUM_W-1:0]);
	assign new_h  = !acc ? hits_q : (h_sum[cmpc_pkg::HITS_W] ? cmpc_pkg::HITS_MAX
		: h_sum[cmpc_pkg::HITS_W-1:0]);

	assign div_start = take && q_item.meta.fend && (new_h != '0);
	assign finish    = (state_q == ST_DIV) && !busy_x && !busy_y && out_free;

	assign cx = (quo_x[cmpc_pkg::SUM_W-1:cmpc_pkg::COORD_W] != '0) ? cmpc_pkg::COORD_MAX
		: quo_x[cmpc_pkg::COORD_W-1:0];
	assign cy = (quo_y[cmpc_pkg::SUM_W-1:cmpc_pkg::COORD_W] != '0) ? cmpc_pkg::COORD_MAX
		: quo_y[cmpc_pkg::COORD_W-1:0];

	cmpc_div u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (new_sx),
		.den    (new_h),
		.busy   (busy_x),
		.quo    (quo_x)
	);

	cmpc_div u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (new_sy),
		.den    (new_h),
		.busy   (busy_y),
		.quo    (quo_y)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			sx_q        <= '0;
			sy_q        <= '0;
			hits_q      <= '0;
			last_cx_q   <= '0;
			last_cy_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				if (q_item.meta.fend) begin
					sx_q   <= '0;
					sy_q   <= '0;
					hits_q <= '0;
				end else begin
					sx_q   <= new_sx;
					sy_q   <= new_sy;
					hits_q <= new_h;
				end
				if (div_start) begin
					state_q <= ST_DIV;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
			if (finish) begin
				state_q     <= ST_RUN;
				last_cx_q   <= cx;
				last_cy_q   <= cy;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_hit_q  <= q_item.hit;
			pend_hits_q <= new_h;
			out_hit_q   <= q_item.hit;
			out_fend_q  <= q_item.meta.fend;
			out_upd_q   <= 1'b0;
			out_hits_q  <= '0;
			out_cx_q    <= q_item.meta.fend ? last_cx_q : '0;
			out_cy_q    <= q_item.meta.fend ? last_cy_q : '0;
		end else if (finish) begin
			out_hit_q  <= pend_hit_q;
			out_fend_q <= 1'b1;
			out_upd_q  <= 1'b1;
			out_hits_q <= pend_hits_q;
			out_cx_q   <= cx;
			out_cy_q   <= cy;
		end
	end

	assign empty            = !out_valid_q;
	assign in_model         = out_hit_q;
	assign frame_done       = out_fend_q;
	assign centroid_x       = out_cx_q;
	assign centroid_y       = out_cy_q;
	assign centroid_updated = out_upd_q;
	assign hit_count        = out_hits_q;

	a_fend_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && q_item.meta.fend) |=> (hits_q == '0 && sx_q == '0 && sy_q == '0))
		else $error("sums not cleared after frame end");

	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_x || busy_y) |-> (state_q == ST_DIV))
		else $error("divider running outside divide state");

	a_done_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		finish |-> (pend_hits_q != '0))
		else $error("centroid divide with zero count");

endmodule

`default_nettype wire

/* hw/rtl/color_model_pixel_classifier_centroid_top.sv */
// Path: a pixel goes through the 5-stage front pipe, the queue and the output register to the
// result ports; a frame-end pixel with hits waits for the two parallel centroid dividers.
// Throughput: one pixel per cycle while full is low; each frame end with hits holds the back
// end for the divide (one quotient bit a cycle); the front keeps filling its pipe and queue.
// Reset (arst_n, asynchronous): clears sums, count, last centroid and all handshake
// state; configuration returns to mean 0x808080 and zero for the other registers.
`default_nettype none

module color_model_pixel_classifier_centroid_top (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [cmpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [cmpc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire                                 push,
	output logic                                full,
	input  wire  [cmpc_pkg::CHAN_W-1:0]         lightness,
	input  wire  [cmpc_pkg::CHAN_W-1:0]         chroma_a,
	input  wire  [cmpc_pkg::CHAN_W-1:0]         chroma_b,
	input  wire  [cmpc_pkg::COORD_W-1:0]        pixel_x,
	input  wire  [cmpc_pkg::COORD_W-1:0]        pixel_y,
	input  wire                                 frame_end,
	output logic                                empty,
	input  wire                                 pop,
	output logic                                in_model,
	output logic                                frame_done,
	output logic [cmpc_pkg::COORD_W-1:0]        centroid_x,
	output logic [cmpc_pkg::COORD_W-1:0]        centroid_y,
	output logic                                centroid_updated,
	output logic [cmpc_pkg::HITS_W-1:0]         hit_count
);

	logic                q_push, q_full, q_pop, q_empty;
	cmpc_pkg::cls_item_t q_wr_item, q_rd_item;

	assign cfg_ready = 1'b1;

	cmpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push      (push),
		.full      (full),
		.lightness (lightness),
		.chroma_a  (chroma_a),
		.chroma_b  (chroma_b),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.frame_end (frame_end),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_item    (q_wr_item)
	);

	cmpc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.full    (q_full),
		.pop     (q_pop),
		.rd_item (q_rd_item),
		.empty   (q_empty)
	);

	cmpc_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.q_item           (q_rd_item),
		.q_empty          (q_empty),
		.q_pop            (q_pop),
		.empty            (empty),
		.pop              (pop),
		.in_model         (in_model),
		.frame_done       (frame_done),
		.centroid_x       (centroid_x),
		.centroid_y       (centroid_y),
		.centroid_updated (centroid_updated),
		.hit_count        (hit_count)
	);

endmodule

`default_nettype wire
